// File: rtl/u2u_pkg.sv
`timescale 1ns / 1ps
package u2u_pkg;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // Result status codes
  localparam logic [1:0] ST_UNIT    = 2'd0;
  localparam logic [1:0] ST_TRUNC   = 2'd1;
  localparam logic [1:0] ST_ILLEGAL = 2'd2;

  // Queue entry kinds
  localparam logic [1:0] K_UNIT    = 2'd0;
  localparam logic [1:0] K_PAIR    = 2'd1;
  localparam logic [1:0] K_TRUNC   = 2'd2;
  localparam logic [1:0] K_ILLEGAL = 2'd3;

  localparam logic [15:0] REPLACEMENT = 16'hFFFD;
  localparam logic [5:0]  HI_SUR_TAG  = 6'b110110;
  localparam logic [5:0]  LO_SUR_TAG  = 6'b110111;

  // One classified event: a BMP unit, a pair offset, or an error
  typedef struct packed {
    logic [1:0]  kind;
    logic [19:0] data;  // unit in [15:0]; pair holds code point minus 0x10000
  } entry_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic [1:0]  status;
    logic        run_last;
  } result_t;

  // Sequence length from the lead byte
  function automatic logic [2:0] seq_len(input logic [7:0] b);
    logic [2:0] n;
    if (b < 8'hC0)      n = 3'd1;
    else if (b < 8'hE0) n = 3'd2;
    else if (b < 8'hF0) n = 3'd3;
    else if (b < 8'hF8) n = 3'd4;
    else if (b < 8'hFC) n = 3'd5;
    else                n = 3'd6;
    return n;
  endfunction

  // Second-byte range check, narrowed for a few lead bytes
  function automatic logic second_ok(input logic [7:0] lead, input logic [7:0] a);
    logic ok;
    unique case (lead)
      8'hE0:   ok = (a >= 8'hA0) && (a <= 8'hBF);
      8'hED:   ok = (a >= 8'h80) && (a <= 8'h9F);
      8'hF0:   ok = (a >= 8'h90) && (a <= 8'hBF);
      8'hF4:   ok = (a >= 8'h80) && (a <= 8'h8F);
      default: ok = (a >= 8'h80) && (a <= 8'hBF);
    endcase
    return ok;
  endfunction

endpackage

// File: rtl/u2u_if.sv
`timescale 1ns / 1ps
// Byte stream channel
interface u2u_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       stream_end;
  modport source (output valid, output in_byte, output stream_end, input ready);
  modport sink   (input valid, input in_byte, input stream_end, output ready);
endinterface

// UTF-16 result channel
interface u2u_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic [1:0]  status;
  logic        run_last;
  modport source (output valid, output code_unit, output status, output run_last,
                  input ready);
  modport sink   (input valid, input code_unit, input status, input run_last,
                  output ready);
endinterface

// Configuration write channel (strict_mode)
interface u2u_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/u2u_front.sv
`timescale 1ns / 1ps
module u2u_front
  import u2u_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       strict_mode,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       stream_end,
  input  logic       q_full,
  output logic       push,
  output entry_t     push_entry
);

  logic [20:0] partial_code, partial_code_next;
  logic [2:0]  bytes_needed, bytes_needed_next;
  logic [2:0]  bytes_seen, bytes_seen_next;
  logic [7:0]  lead_byte, lead_byte_next;
  logic        bad_pending, bad_pending_next;
  logic        halted, halted_next;

  logic        accept;
  logic [2:0]  len;
  logic [7:0]  lead_mask;
  logic [20:0] pc;
  logic [2:0]  seen;
  logic [7:0]  lead;
  logic        bad;
  logic [2:0]  needed;
  logic [20:0] cp_off;
  logic        is_sur;
  logic        is_big;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign len       = seq_len(in_byte);
  assign lead_mask = 8'h7F >> len;
  assign cp_off    = pc - 21'h010000;
  assign is_sur    = (pc[20:16] == 5'd0) && (pc[15:11] == 5'b11011);
  assign is_big    = pc > 21'h10FFFF;

  // Fold the byte into the current sequence
  always_comb begin
    if (bytes_needed == 3'd0) begin
      lead   = in_byte;
      needed = len;
      seen   = 3'd1;
      if (len == 3'd1) begin
        bad = in_byte[7];
        pc  = {13'd0, in_byte};
      end else begin
        bad = (len > 3'd4) || (in_byte < 8'hC2) || (in_byte > 8'hF4);
        pc  = {13'd0, in_byte & lead_mask};
      end
    end else begin
      lead   = lead_byte;
      needed = bytes_needed;
      seen   = bytes_seen + 3'd1;
      bad    = bad_pending;
      if (seen == 3'd2) begin
        if (!second_ok(lead_byte, in_byte)) bad = 1'b1;
      end else if (seen <= 3'd4) begin
        if (in_byte[7:6] != 2'b10) bad = 1'b1;
      end
      pc = {partial_code[14:0], in_byte[5:0]};
    end
  end

  // Sequencing and classification
  always_comb begin
    partial_code_next = partial_code;
    bytes_needed_next = bytes_needed;
    bytes_seen_next   = bytes_seen;
    lead_byte_next    = lead_byte;
    bad_pending_next  = bad_pending;
    halted_next       = halted;
    push              = 1'b0;
    push_entry        = '{kind: K_UNIT, data: 20'd0};
    if (accept) begin
      if (halted) begin
        if (stream_end) begin
          partial_code_next = '0;
          bytes_needed_next = '0;
          bytes_seen_next   = '0;
          lead_byte_next    = '0;
          bad_pending_next  = 1'b0;
          halted_next       = 1'b0;
        end
      end else if (seen < needed) begin
        if (stream_end) begin
          partial_code_next = '0;
          bytes_needed_next = '0;
          bytes_seen_next   = '0;
          lead_byte_next    = '0;
          bad_pending_next  = 1'b0;
          push              = 1'b1;
          push_entry.kind   = K_TRUNC;
        end else begin
          partial_code_next = pc;
          bytes_needed_next = needed;
          bytes_seen_next   = seen;
          lead_byte_next    = lead;
          bad_pending_next  = bad;
        end
      end else begin
        // Sequence complete
        partial_code_next = '0;
        bytes_needed_next = '0;
        bytes_seen_next   = '0;
        lead_byte_next    = '0;
        bad_pending_next  = 1'b0;
        push              = 1'b1;
        if (bad || ((is_sur || is_big) && strict_mode)) begin
          push_entry.kind = K_ILLEGAL;
          halted_next     = !stream_end;
        end else if (is_sur || is_big) begin
          push_entry.data = {4'd0, REPLACEMENT};
        end else if (pc[20:16] == 5'd0) begin
          push_entry.data = {4'd0, pc[15:0]};
        end else begin
          push_entry.kind = K_PAIR;
          push_entry.data = cp_off[19:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_code <= '0;
      bytes_needed <= '0;
      bytes_seen   <= '0;
      lead_byte    <= '0;
      bad_pending  <= 1'b0;
      halted       <= 1'b0;
    end else begin
      partial_code <= partial_code_next;
      bytes_needed <= bytes_needed_next;
      bytes_seen   <= bytes_seen_next;
      lead_byte    <= lead_byte_next;
      bad_pending  <= bad_pending_next;
      halted       <= halted_next;
    end
  end

endmodule

// File: rtl/u2u_queue.sv
`timescale 1ns / 1ps
module u2u_queue
  import u2u_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  entry_t       push_entry,
  input  logic         pop,
  output entry_t       head,
  output logic         empty,
  output logic         full,
  output logic [QAW:0] count
);

  entry_t         slots [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;

  assign head  = slots[rd_ptr];
  assign empty = (count == '0);
  assign full  = (count == (QAW+1)'(QDEPTH));

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

// File: rtl/u2u_back.sv
`timescale 1ns / 1ps
module u2u_back
  import u2u_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  entry_t  head,
  input  logic    empty,
  output logic    pop,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_beat
);

  logic    load;
  logic    half;   // high surrogate of the head entry already loaded into the output register
  result_t beat_next;

  assign load = !empty && (!out_valid || out_ready);
  assign pop  = load && ((head.kind != K_PAIR) || half);

  // Expand the head entry into a result beat
  always_comb begin
    unique case (head.kind)
      K_UNIT:    beat_next = '{code_unit: head.data[15:0], status: ST_UNIT, run_last: 1'b1};
      K_PAIR: begin
        if (half) begin
          beat_next = '{code_unit: {LO_SUR_TAG, head.data[9:0]}, status: ST_UNIT,
                        run_last: 1'b1};
        end else begin
          beat_next = '{code_unit: {HI_SUR_TAG, head.data[19:10]}, status: ST_UNIT,
                        run_last: 1'b0};
        end
      end
      K_TRUNC:   beat_next = '{code_unit: 16'd0, status: ST_TRUNC, run_last: 1'b1};
      K_ILLEGAL: beat_next = '{code_unit: 16'd0, status: ST_ILLEGAL, run_last: 1'b1};
      default:   beat_next = '{code_unit: 16'd0, status: ST_ILLEGAL, run_last: 1'b1};
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (load) begin
      out_beat <= beat_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      half      <= 1'b0;
    end else begin
      if (load)           out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (load && head.kind == K_PAIR) half <= !half;
    end
  end

endmodule

// File: rtl/utf8_to_utf16_decoder_core.sv
`timescale 1ns / 1ps
// Channel  Port   Dir   Payload                        Beat
// -------  -----  ----  -----------------------------  --------------------------
// bytes    text   sink  in_byte[7:0], stream_end       one UTF-8 byte
// results  units  src   code_unit[15:0], status[1:0],  one UTF-16 unit or error
//                       run_last
// config   cfg    sink  data (strict_mode)             one register write
//
// One byte beat per cycle while the queue is not full; a byte is decoded in
// the cycle it is taken. A BMP unit or error passes through the queue into the
// single output register of the back end; a surrogate pair leaves as two beats.
// A four-entry queue parts decode from output; bytes stall only when it is full.
// Synchronous reset clears the decoder state, the queue and the output valid,
// and sets strict_mode to 1. Config writes are always taken.
module utf8_to_utf16_decoder_core
  import u2u_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  u2u_in_if.sink    text,
  u2u_out_if.source units,
  u2u_cfg_if.sink   cfg
);

  logic         strict_mode;
  logic         q_full;
  logic         q_empty;
  logic [QAW:0] q_count;
  logic         push;
  logic         pop;
  entry_t       push_entry;
  entry_t       head;
  result_t      out_beat;

  // Configuration register
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      strict_mode <= 1'b1;
    end else if (cfg.valid) begin
      strict_mode <= cfg.data;
    end
  end

  u2u_front front_u (
    .clk        (clk),
    .rst        (rst),
    .strict_mode(strict_mode),
    .in_valid   (text.valid),
    .in_ready   (text.ready),
    .in_byte    (text.in_byte),
    .stream_end (text.stream_end),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  u2u_queue queue_u (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full),
    .count     (q_count)
  );

  u2u_back back_u (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .empty    (q_empty),
    .pop      (pop),
    .out_valid(units.valid),
    .out_ready(units.ready),
    .out_beat (out_beat)
  );

  assign units.code_unit = out_beat.code_unit;
  assign units.status    = out_beat.status;
  assign units.run_last  = out_beat.run_last;

  // Byte channel backs off exactly when the queue is full
  a_full_stalls: assert property (@(posedge clk) disable iff (rst)
    (q_count == (QAW+1)'(QDEPTH)) |-> !text.ready)
    else $error("byte accepted while queue full");

  // Error beats carry a zero unit and close their byte's results
  a_error_beat: assert property (@(posedge clk) disable iff (rst)
    (units.valid && units.status != ST_UNIT) |-> (units.code_unit == 16'd0 && units.run_last))
    else $error("malformed error beat");

  // A non-final beat is always the high surrogate of a pair
  a_high_first: assert property (@(posedge clk) disable iff (rst)
    (units.valid && !units.run_last) |-> (units.code_unit[15:10] == HI_SUR_TAG))
    else $error("non-final beat is not a high surrogate");

endmodule

// File: tb/utf8_to_utf16_decoder_core_tb.sv
`timescale 1ns / 1ps
module utf8_to_utf16_decoder_core_tb;
  import u2u_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE_TICKS = 16;
  localparam int LONG_HOLD    = 300;
  localparam int MAX_REPORTS  = 60;

  localparam logic [15:0] HI_SUR_BASE = 16'hD800;
  localparam logic [15:0] LO_SUR_BASE = 16'hDC00;

  // One byte beat waiting to be offered
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } text_beat_t;

  // Opening directed stream, {end mark, byte}
  localparam logic [8:0] OPENING [25] = '{
    9'h000, 9'h07F,                          // ASCII extremes
    9'h0DF, 9'h0BF,                          // top of two-byte range
    9'h0EF, 9'h0BF, 9'h0BF,                  // top of BMP
    9'h0F4, 9'h08F, 9'h0BF, 9'h0BF,          // highest code point, pair
    9'h0ED, 9'h0A0, 9'h080,                  // encoded surrogate, halts
    9'h041, 9'h142,                          // ignored, end mark rearms
    9'h1C2,                                  // cut off by end mark
    9'h0C0, 9'h180,                          // overlong lead, error on end byte
    9'h0FF, 9'h080, 9'h080, 9'h080, 9'h080, 9'h180  // six-byte lead
  };

  logic clk;
  logic rst;

  u2u_in_if  text_if ();
  u2u_out_if units_if ();
  u2u_cfg_if cfg_if ();

  utf8_to_utf16_decoder_core DUT (
    .clk   (clk),
    .rst   (rst),
    .text  (text_if),
    .units (units_if),
    .cfg   (cfg_if)
  );

  // Clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Scoreboard state
  text_beat_t pending_bytes [$];
  result_t    expected_units [$];
  result_t    want;
  int         bytes_queued;
  int         bytes_taken;
  int         mismatches;
  int         cycle_count;
  int         hold_reqs;

  // Decoder copy used for prediction
  logic [20:0] acc_cp;
  logic [2:0]  seq_need;
  logic [2:0]  seq_got;
  logic [7:0]  seq_lead;
  logic        seq_bad;
  logic        skip_to_end;
  logic        strict_copy;

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_REPORTS)
      $display("MISMATCH cycle %0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  function automatic logic [2:0] lead_length(input logic [7:0] b);
    if (b < 8'hC0) return 3'd1;
    if (b < 8'hE0) return 3'd2;
    if (b < 8'hF0) return 3'd3;
    if (b < 8'hF8) return 3'd4;
    if (b < 8'hFC) return 3'd5;
    return 3'd6;
  endfunction

  // Second byte range, tightened for E0, ED, F0 and F4 leads
  function automatic logic cont_ok(input logic [7:0] lead, input logic [7:0] a);
    logic lo_ok;
    logic hi_ok;
    lo_ok = (a >= 8'h80);
    hi_ok = (a <= 8'hBF);
    case (lead)
      8'hE0: lo_ok = (a >= 8'hA0);
      8'hED: hi_ok = (a <= 8'h9F);
      8'hF0: lo_ok = (a >= 8'h90);
      8'hF4: hi_ok = (a <= 8'h8F);
      default: ;
    endcase
    return lo_ok && hi_ok;
  endfunction

  function automatic void clear_seq();
    acc_cp   = '0;
    seq_need = '0;
    seq_got  = '0;
    seq_lead = '0;
    seq_bad  = 1'b0;
  endfunction

  function automatic void expect_unit(input logic [15:0] cu, input logic [1:0] st,
                                      input logic fin);
    result_t r;
    r.code_unit = cu;
    r.status    = st;
    r.run_last  = fin;
    expected_units.push_back(r);
  endfunction

  // Substitution or error for code points outside the UTF-16 range
  function automatic void out_of_range(input logic last);
    if (strict_copy) begin
      skip_to_end = !last;
      expect_unit(16'h0000, ST_ILLEGAL, 1'b1);
    end else begin
      expect_unit(REPLACEMENT, ST_UNIT, 1'b1);
    end
  endfunction

  // Advance the decoder copy by one byte and queue what it yields
  function automatic void decode_byte(input logic [7:0] b, input logic last);
    logic [20:0] cp;
    logic [20:0] off;
    if (skip_to_end) begin
      if (last) begin
        clear_seq();
        skip_to_end = 1'b0;
      end
      return;
    end
    if (seq_need == 0) begin
      seq_need = lead_length(b);
      seq_lead = b;
      seq_got  = 3'd1;
      if (seq_need == 1) begin
        seq_bad = b[7];
        acc_cp  = {13'b0, b};
      end else begin
        seq_bad = (seq_need > 4) || (b < 8'hC2) || (b > 8'hF4);
        acc_cp  = {13'b0, b & (8'h7F >> seq_need)};
      end
    end else begin
      seq_got = seq_got + 3'd1;
      if (seq_got == 2) begin
        if (!cont_ok(seq_lead, b)) seq_bad = 1'b1;
      end else if (seq_got <= 4) begin
        if (b[7:6] != 2'b10) seq_bad = 1'b1;
      end
      acc_cp = {acc_cp[14:0], b[5:0]};
    end

    if (seq_got < seq_need) begin
      if (last) begin
        clear_seq();
        expect_unit(16'h0000, ST_TRUNC, 1'b1);
      end
      return;
    end

    cp = acc_cp;
    if (seq_bad) begin
      clear_seq();
      skip_to_end = !last;
      expect_unit(16'h0000, ST_ILLEGAL, 1'b1);
      return;
    end
    clear_seq();

    if (cp <= 21'h00FFFF) begin
      if (cp >= 21'h00D800 && cp <= 21'h00DFFF) out_of_range(last);
      else expect_unit(cp[15:0], ST_UNIT, 1'b1);
    end else if (cp > 21'h10FFFF) begin
      out_of_range(last);
    end else begin
      off = cp - 21'h010000;
      expect_unit(HI_SUR_BASE + {6'b0, off[19:10]}, ST_UNIT, 1'b0);
      expect_unit(LO_SUR_BASE + {6'b0, off[9:0]}, ST_UNIT, 1'b1);
    end
  endfunction

  // Byte driver: bursts of random length with random gaps
  int burst_left;
  int gap_left;
  text_beat_t next_beat;

  always @(posedge clk) begin
    if (rst) begin
      text_if.valid      <= 1'b0;
      text_if.in_byte    <= 8'h00;
      text_if.stream_end <= 1'b0;
      burst_left         <= 0;
      gap_left           <= 0;
    end else if (!text_if.valid || text_if.ready) begin
      if (gap_left != 0) begin
        text_if.valid <= 1'b0;
        gap_left      <= gap_left - 1;
      end else if (pending_bytes.size() != 0) begin
        next_beat = pending_bytes.pop_front();
        text_if.valid      <= 1'b1;
        text_if.in_byte    <= next_beat.data;
        text_if.stream_end <= next_beat.last;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        text_if.valid <= 1'b0;
      end
    end
  end

  // Result receiver: stall modes of its own, plus long hold-offs on request
  int         hold_seen;
  int         hold_left;
  int         mode_left;
  int         stall_mode;
  logic [7:0] stall_pattern;

  always @(posedge clk) begin
    if (rst) begin
      units_if.ready <= 1'b0;
      hold_seen      <= 0;
      hold_left      <= 0;
      mode_left      <= 0;
      stall_mode     <= 0;
      stall_pattern  <= 8'b1011_0010;
    end else if (hold_seen != hold_reqs) begin
      hold_seen      <= hold_reqs;
      hold_left      <= LONG_HOLD;
      units_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left      <= hold_left - 1;
      units_if.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left  <= $urandom_range(16, 96);
      end else begin
        mode_left <= mode_left - 1;
      end
      stall_pattern <= {stall_pattern[0], stall_pattern[7:1]};
      case (stall_mode)
        0:       units_if.ready <= 1'b1;
        1:       units_if.ready <= $urandom_range(0, 1);
        2:       units_if.ready <= ($urandom_range(0, 3) == 0);
        default: units_if.ready <= stall_pattern[0];
      endcase
    end
  end

  // Monitor: check result beats, then feed accepted byte beats to the predictor
  always @(posedge clk) begin
    if (!rst) begin
      if (units_if.valid && units_if.ready) begin
        if (expected_units.size() == 0) begin
          report_mismatch($sformatf("unexpected unit %h status %0d last %0b",
                                    units_if.code_unit, units_if.status, units_if.run_last));
        end else begin
          want = expected_units.pop_front();
          if (units_if.code_unit !== want.code_unit)
            report_mismatch($sformatf("code_unit %h, want %h",
                                      units_if.code_unit, want.code_unit));
          if (units_if.status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", units_if.status, want.status));
          if (units_if.run_last !== want.run_last)
            report_mismatch($sformatf("run_last %0b, want %0b",
                                      units_if.run_last, want.run_last));
        end
      end
      if (text_if.valid && text_if.ready) begin
        decode_byte(text_if.in_byte, text_if.stream_end);
        bytes_taken++;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic void queue_byte(input logic [7:0] b, input logic last);
    text_beat_t t;
    t.data = b;
    t.last = last;
    pending_bytes.push_back(t);
    bytes_queued++;
  endfunction

  function automatic logic [7:0] cont_byte();
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  // One sequence: mostly well-formed, some cut short, corrupted or noise
  task automatic add_sequence();
    logic [7:0]  seq [$];
    logic [20:0] cp;
    int          kind;
    int          n;
    int          keep;
    logic        force_end;
    kind      = $urandom_range(0, 99);
    force_end = 1'b0;
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 9))
        0: cp = 21'h000000;
        1: cp = 21'h00007F;
        2: cp = 21'h000080;
        3: cp = 21'h0007FF;
        4: cp = 21'h000800;
        5: cp = 21'h00D7FF;
        6: cp = 21'h00E000;
        7: cp = 21'h00FFFF;
        8: cp = 21'h010000;
        default: cp = 21'h10FFFF;
      endcase
    end else begin
      case ($urandom_range(1, 4))
        1: cp = 21'($urandom_range(0, 'h7F));
        2: cp = 21'($urandom_range('h80, 'h7FF));
        3: begin
          cp = 21'($urandom_range('h800, 'hFFFF));
          if (cp >= 21'h00D800 && cp <= 21'h00DFFF) cp = cp - 21'h000800;
        end
        default: cp = 21'($urandom_range('h10000, 'h10FFFF));
      endcase
    end

    // UTF-8 encoding
    if (cp < 21'h80) begin
      seq.push_back(cp[7:0]);
    end else if (cp < 21'h800) begin
      seq.push_back({3'b110, cp[10:6]});
      seq.push_back({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      seq.push_back({4'b1110, cp[15:12]});
      seq.push_back({2'b10, cp[11:6]});
      seq.push_back({2'b10, cp[5:0]});
    end else begin
      seq.push_back({5'b11110, cp[20:18]});
      seq.push_back({2'b10, cp[17:12]});
      seq.push_back({2'b10, cp[11:6]});
      seq.push_back({2'b10, cp[5:0]});
    end

    if (kind < 55) begin
      // well-formed as is
    end else if (kind < 65) begin
      // cut short by the end mark
      if (seq.size() > 1) begin
        keep = $urandom_range(1, seq.size() - 1);
        while (seq.size() > keep) void'(seq.pop_back());
      end
      force_end = 1'b1;
    end else if (kind < 78) begin
      seq[$urandom_range(0, seq.size() - 1)] = 8'($urandom_range(0, 255));
    end else if (kind < 90) begin
      // lead bytes and second bytes at the edges of the legal ranges
      seq.delete();
      case ($urandom_range(0, 6))
        0: begin
          seq.push_back(8'($urandom_range('hC0, 'hC1)));
          seq.push_back(cont_byte());
        end
        1: begin
          seq.push_back(8'($urandom_range('hF5, 'hFF)));
          n = $urandom_range(3, 5);
          repeat (n) seq.push_back(cont_byte());
        end
        2: begin
          seq.push_back(8'hE0);
          seq.push_back(8'($urandom_range('h80, 'h9F)));
          seq.push_back(cont_byte());
        end
        3: begin
          seq.push_back(8'hED);
          seq.push_back(8'($urandom_range('hA0, 'hBF)));
          seq.push_back(cont_byte());
        end
        4: begin
          seq.push_back(8'hF0);
          seq.push_back(8'($urandom_range('h80, 'h8F)));
          seq.push_back(cont_byte());
          seq.push_back(cont_byte());
        end
        5: begin
          seq.push_back(8'hF4);
          seq.push_back(8'($urandom_range('h90, 'hBF)));
          seq.push_back(cont_byte());
          seq.push_back(cont_byte());
        end
        default: seq.push_back(8'($urandom_range('h80, 'hBF)));
      endcase
    end else begin
      n = $urandom_range(1, 6);
      repeat (n) seq.push_back(8'($urandom_range(0, 255)));
    end

    for (int i = 0; i < seq.size(); i++)
      queue_byte(seq[i], (i == seq.size() - 1) &&
                         (force_end || ($urandom_range(0, 4) == 0)));
  endtask

  task automatic queue_random(input int target);
    int start;
    start = bytes_queued;
    while (bytes_queued - start < target) add_sequence();
  endtask

  // Sender pause: wait until every byte is taken and every unit is back
  task automatic wait_drained();
    do @(negedge clk);
    while (bytes_taken != bytes_queued || expected_units.size() != 0);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic write_strict(input logic v);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= v;
    do @(posedge clk);
    while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    strict_copy = v;
  endtask

  // Sequencer
  initial begin
    rst                = 1'b1;
    text_if.valid      = 1'b0;
    text_if.in_byte    = 8'h00;
    text_if.stream_end = 1'b0;
    units_if.ready     = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.data        = 1'b0;
    bytes_queued       = 0;
    bytes_taken        = 0;
    mismatches         = 0;
    cycle_count        = 0;
    hold_reqs          = 0;
    strict_copy        = 1'b1;
    skip_to_end        = 1'b0;
    clear_seq();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed stream at reset strictness
    @(negedge clk);
    foreach (OPENING[i]) queue_byte(OPENING[i][7:0], OPENING[i][8]);
    wait_drained();

    write_strict(1'b0);
    @(negedge clk);
    queue_random(250);
    wait_drained();

    // Receiver holds off while the sender keeps offering: queue fills, input stalls
    write_strict(1'b1);
    @(negedge clk);
    hold_reqs = hold_reqs + 1;
    queue_random(200);
    wait_drained();

    write_strict(1'b0);
    @(negedge clk);
    queue_random(200);
    wait_drained();

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
